>>> sv/rgbhsv_pkg.sv
// Shared constants and types for the RGB to HSV conversion pipeline.
package rgbhsv_pkg;

  // Default width of one color component
  localparam int COMPONENT_BITS = 8;

  // Hue scale: 1/64 degree units, one sixth of the circle and the full circle
  localparam int HUE_W     = 15;
  localparam int HUE_SIXTH = 3840;
  localparam int HUE_FULL  = 23040;

  // Hue quotient never exceeds one sixth, so it fits in this many bits
  localparam int HUE_QUO_W = 12;

  // Which component is the largest (ties go to red, then green)
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

>>> sv/rgbhsv_div.sv
// Fully pipelined restoring divider, one quotient bit per register stage.
module rgbhsv_div #(
  parameter int DEN_W = rgbhsv_pkg::COMPONENT_BITS,
  parameter int QUO_W = rgbhsv_pkg::HUE_QUO_W
) (
  input  logic                   clk,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int WORK_W = DEN_W + QUO_W;

  // Upper DEN_W bits hold the partial remainder, lower bits hold the
  // dividend bits still to come, with quotient bits shifted in behind them.
  // The caller guarantees num >> QUO_W < den, so the quotient fits.
  logic [WORK_W-1:0] work [QUO_W+1];
  logic [DEN_W-1:0]  dv   [QUO_W+1];

  assign work[0] = num;
  assign dv[0]   = den;

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
      trial = work[s][WORK_W-1:QUO_W-1];
      diff  = trial - {1'b0, dv[s]};
      take  = (trial >= {1'b0, dv[s]});
    end

    always_ff @(posedge clk) begin
      if (take) begin
        work[s+1] <= {diff[DEN_W-1:0], work[s][QUO_W-2:0], 1'b1};
      end else begin
        work[s+1] <= {trial[DEN_W-1:0], work[s][QUO_W-2:0], 1'b0};
      end
      dv[s+1] <= dv[s];
    end
  end

  assign quo = work[QUO_W][QUO_W-1:0];

endmodule

>>> sv/rgb_to_hsv_unit.sv
// Top level: pipelined RGB to HSV pixel conversion.
//
//   channel  | signals                        | handshake
//   ---------+--------------------------------+------------------------------
//   pixel in | red, green, blue               | start high and busy low
//   hsv out  | hue, saturation, value         | done high for one cycle
//
// The pipeline has two stages that find max, min and the dividends, one
// stage per quotient bit in the two dividers, and one stage that forms hue
// and saturation. A pixel may enter every cycle; busy is never raised.
// Reset clears the valid bits only; results in flight are dropped. The
// receiver cannot stall, so nothing ever holds the pipeline.
module rgb_to_hsv_unit #(
  parameter int COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [COMPONENT_BITS-1:0]       red,
  input  logic [COMPONENT_BITS-1:0]       green,
  input  logic [COMPONENT_BITS-1:0]       blue,
  output logic                            done,
  output logic [rgbhsv_pkg::HUE_W-1:0]    hue,
  output logic [COMPONENT_BITS-1:0]       saturation,
  output logic [COMPONENT_BITS-1:0]       value
);

  localparam int W       = COMPONENT_BITS;
  localparam int QH      = rgbhsv_pkg::HUE_QUO_W;
  localparam int Q       = (W > QH) ? W : QH;
  localparam int HNUM_W  = Q + W;
  localparam int SNUM_W  = Q + W + 1;
  localparam int LATENCY = Q + 3;

  // Per-beat control that rides alongside the dividers
  typedef struct packed {
    logic                valid;
    rgbhsv_pkg::sector_t sector;
    logic                neg;
    logic                gray;
    logic                black;
    logic [W-1:0]        hi;
  } side_t;

  assign busy = 1'b0;

  // ---------------- stage A: max, min, sector, signed difference
  logic                a_valid;
  rgbhsv_pkg::sector_t a_sector;
  logic                a_neg;
  logic [W-1:0]        a_mag;
  logic [W-1:0]        a_hi;
  logic [W-1:0]        a_range;

  rgbhsv_pkg::sector_t sector_next;
  logic [W-1:0]        hi_next;
  logic [W-1:0]        lo_next;
  logic [W-1:0]        dx;
  logic [W-1:0]        dy;

  always_comb begin
    if (red >= green && red >= blue) begin
      sector_next = rgbhsv_pkg::SEC_RED;
      hi_next     = red;
      dx          = green;
      dy          = blue;
    end else if (green >= blue) begin
      sector_next = rgbhsv_pkg::SEC_GREEN;
      hi_next     = green;
      dx          = blue;
      dy          = red;
    end else begin
      sector_next = rgbhsv_pkg::SEC_BLUE;
      hi_next     = blue;
      dx          = red;
      dy          = green;
    end
    lo_next = red;
    if (green < lo_next) lo_next = green;
    if (blue < lo_next) lo_next = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_sector <= sector_next;
    a_neg    <= (dx < dy);
    a_mag    <= (dx < dy) ? (dy - dx) : (dx - dy);
    a_hi     <= hi_next;
    a_range  <= hi_next - lo_next;
  end

  // ---------------- stage B: dividends and divisors
  logic [HNUM_W-1:0] b_hue_num;
  logic [SNUM_W-1:0] b_sat_num;
  logic [W-1:0]      b_range;
  logic [W:0]        b_hi2;
  side_t             side_in;
  side_t             side_pipe [Q+1];

  always_ff @(posedge clk) begin
    b_hue_num <= HNUM_W'(a_mag) * HNUM_W'(rgbhsv_pkg::HUE_SIXTH);
    // 2*FULL*range + hi, with FULL = 2^W - 1
    b_sat_num <= (SNUM_W'(a_range) << (W + 1)) - (SNUM_W'(a_range) << 1)
               + SNUM_W'(a_hi);
    b_range   <= a_range;
    b_hi2     <= {a_hi, 1'b0};
  end

  // Side-band beat entering the control line
  always_comb begin
    side_in.valid  = a_valid;
    side_in.sector = a_sector;
    side_in.neg    = a_neg;
    side_in.gray   = (a_range == '0);
    side_in.black  = (a_hi == '0);
    side_in.hi     = a_hi;
  end

  // ---------------- divider stages
  logic [Q-1:0] hue_quo;
  logic [Q-1:0] sat_quo;

  rgbhsv_div #(.DEN_W(W), .QUO_W(Q)) u_hue_div (
    .clk (clk),
    .num (b_hue_num),
    .den (b_range),
    .quo (hue_quo)
  );

  rgbhsv_div #(.DEN_W(W + 1), .QUO_W(Q)) u_sat_div (
    .clk (clk),
    .num (b_sat_num),
    .den (b_hi2),
    .quo (sat_quo)
  );

  // Control shift line matched to the divider depth
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= Q; i++) begin
        side_pipe[i].valid <= 1'b0;
      end
    end else begin
      side_pipe[0] <= side_in;
      for (int i = 1; i <= Q; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  // ---------------- output stage: sector base, sign and wrap
  side_t               side_out;
  logic [QH-1:0]       hq;
  logic [16:0]         base;
  logic signed [16:0]  hsum;

  assign side_out = side_pipe[Q];
  assign hq       = hue_quo[QH-1:0];

  always_comb begin
    case (side_out.sector)
      rgbhsv_pkg::SEC_RED:   base = 17'd0;
      rgbhsv_pkg::SEC_GREEN: base = 17'(2 * rgbhsv_pkg::HUE_SIXTH);
      rgbhsv_pkg::SEC_BLUE:  base = 17'(4 * rgbhsv_pkg::HUE_SIXTH);
      default:               base = 17'd0;
    endcase
    if (side_out.neg) begin
      hsum = $signed(base - 17'(hq));
    end else begin
      hsum = $signed(base + 17'(hq));
    end
    if (hsum < 0) begin
      hsum = hsum + $signed(17'(rgbhsv_pkg::HUE_FULL));
    end
    if (side_out.gray) begin
      hsum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_out.valid;
    end
    hue        <= hsum[rgbhsv_pkg::HUE_W-1:0];
    saturation <= side_out.black ? '0 : sat_quo[W-1:0];
    value      <= side_out.hi;
  end

  // ---------------- assertions
  a_latency_hit: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("accepted pixel did not come out after the pipeline latency");

  a_latency_miss: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##LATENCY !done)
    else $error("result beat without a matching accepted pixel");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL)))
    else $error("hue beyond full circle");

  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (done && saturation == '0) |-> (hue == '0))
    else $error("unsaturated pixel with nonzero hue");

endmodule
